FILE: rtl/gregorian_date_offset_and_day_number_macros.svh
// Assertion macros for the Gregorian date offset block.
// Used by the top level only; needs no package.
`ifndef GREGORIAN_DATE_OFFSET_AND_DAY_NUMBER_MACROS_SVH
`define GREGORIAN_DATE_OFFSET_AND_DAY_NUMBER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GDO_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdo assertion failed");

// Next-cycle implication, disabled during reset
`define GDO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gdo assertion failed");

`endif

FILE: rtl/gdo_pkg.sv
// Shared widths, constants, types and calendar functions of the date block.
// No dependencies; used by every other file but the macros header.
package gdo_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int OFFSET_W = 16;
   localparam int SERIAL_W = 22;
   localparam int SUM_W    = 24;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [YEAR_W-1:0]   YEAR_MIN   = 14'd1;
   localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;
   localparam logic [SERIAL_W-1:0] SERIAL_MIN = 22'd1;
   localparam logic [SERIAL_W-1:0] SERIAL_MAX = 22'd3652059;

   // Month numbers
   localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

   // Calendar constants
   localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
   localparam logic [10:0] DAYS_PER_4Y   = 11'd1461;
   localparam logic [15:0] DAYS_PER_100Y = 16'd36524;
   localparam logic [17:0] DAYS_PER_400Y = 18'd146097;
   localparam logic [6:0]  YEARS_CENTURY = 7'd100;
   localparam logic [8:0]  YEARS_400     = 9'd400;
   localparam logic [4:0]  Q4_LAST       = 5'd24;
   localparam logic [1:0]  Q_LAST        = 2'd3;

   // Reciprocal of 100: exact floor for any 14-bit value
   localparam logic [12:0] RECIP100    = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam int          QY_W        = 7;

   // Days before the first of each month in a common year
   localparam logic [8:0] DAYS_BEFORE [12] =
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

   // Queue entry: clamped serial day and range flag
   typedef struct packed {
      logic [SERIAL_W-1:0] serial;
      logic                range_error;
   } gdo_entry_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (mo)
         MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
         MON_FEB: len = leap ? 5'd29 : 5'd28;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: rtl/gdo_if.sv
// Handshake channels of the date block: request and response.
// Depends on gdo_pkg for field widths.
interface gdo_req_if;
   logic                                valid;
   logic                                ready;
   logic [gdo_pkg::YEAR_W-1:0]          year_in;
   logic [gdo_pkg::MONTH_W-1:0]         month_in;
   logic [gdo_pkg::DAY_W-1:0]           day_in;
   logic signed [gdo_pkg::OFFSET_W-1:0] day_offset;

   modport source (output valid, year_in, month_in, day_in, day_offset, input ready);
   modport sink   (input valid, year_in, month_in, day_in, day_offset, output ready);
endinterface

interface gdo_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gdo_pkg::YEAR_W-1:0]   year_out;
   logic [gdo_pkg::MONTH_W-1:0]  month_out;
   logic [gdo_pkg::DAY_W-1:0]    day_out;
   logic [gdo_pkg::SERIAL_W-1:0] day_number;
   logic                        range_error;

   modport source (output valid, year_out, month_out, day_out, day_number, range_error,
                   input ready);
   modport sink   (input valid, year_out, month_out, day_out, day_number, range_error,
                   output ready);
endinterface

FILE: rtl/gdo_front.sv
// Front end: accepts a request item, clamps it and works out its serial day.
// Depends on gdo_pkg and gdo_req_if.
module gdo_front (
   input  logic                   clock,
   input  logic                   reset,
   gdo_req_if.sink                req_chan,
   output logic                   push_valid,
   input  logic                   push_ready,
   output gdo_pkg::gdo_entry_type push_entry
);
   import gdo_pkg::*;

   typedef enum logic [2:0] {F_IDLE, F_DIV, F_MUL, F_SUM, F_PUSH} front_state_type;

   front_state_type       state_ff;
   logic [YEAR_W-1:0]     y_ff, y_in;
   logic [MONTH_W-1:0]    m_ff, m_in;
   logic [DAY_W-1:0]      d_ff;
   logic signed [OFFSET_W-1:0] off_ff;
   logic [QY_W-1:0]       qy_ff, qy_in;
   logic [YEAR_W-1:0]     p_ff, p_in;
   logic [SERIAL_W-1:0]   p365_ff, p365_in;
   logic [QY_W-1:0]       pq_ff, pq_in;
   logic                  leap_ff, leap_in;
   gdo_entry_type         entry_ff, entry_in;

   logic [26:0]           prod_y;
   logic [YEAR_W-1:0]     ry;
   logic signed [SUM_W-1:0] t_p365, t_p4, t_pq, t_pq4, t_db, t_leap, t_d, t_off, t_sum;

   // Clamp incoming year and month
   always_comb begin
      y_in = req_chan.year_in;
      if (req_chan.year_in < YEAR_MIN) begin
         y_in = YEAR_MIN;
      end else if (req_chan.year_in > YEAR_MAX) begin
         y_in = YEAR_MAX;
      end
      m_in = req_chan.month_in;
      if (req_chan.month_in < MON_JAN) begin
         m_in = MON_JAN;
      end else if (req_chan.month_in > MON_DEC) begin
         m_in = MON_DEC;
      end
   end

   // Year divided by 100 through the reciprocal
   assign prod_y = 27'(y_ff) * 27'(RECIP100);
   assign qy_in  = prod_y[RECIP_SHIFT +: QY_W];

   // Remainder, leap flag, elapsed years and their day count
   assign ry      = y_ff - (14'(qy_ff) * 14'(YEARS_CENTURY));
   assign leap_in = (y_ff[1:0] == 2'b00) && ((ry != '0) || (qy_ff[1:0] == 2'b00));
   assign pq_in   = (ry == '0) ? (qy_ff - 7'd1) : qy_ff;
   assign p_in    = y_ff - 14'd1;
   assign p365_in = 22'(p_in) * 22'(DAYS_PER_YEAR);

   // Serial day of the shifted date, then clamp to the supported span
   always_comb begin
      t_p365 = SUM_W'(p365_ff);
      t_p4   = SUM_W'(p_ff[YEAR_W-1:2]);
      t_pq   = SUM_W'(pq_ff);
      t_pq4  = SUM_W'(pq_ff[QY_W-1:2]);
      t_db   = SUM_W'(DAYS_BEFORE[m_ff - 4'd1]);
      t_leap = SUM_W'(leap_ff && (m_ff > MON_FEB));
      t_d    = SUM_W'(d_ff);
      t_off  = SUM_W'(off_ff);
      t_sum  = t_p365 + t_p4 - t_pq + t_pq4 + t_db + t_leap + t_d + t_off;
      if (t_sum < $signed(SUM_W'(SERIAL_MIN))) begin
         entry_in.serial      = SERIAL_MIN;
         entry_in.range_error = 1'b1;
      end else if (t_sum > $signed(SUM_W'(SERIAL_MAX))) begin
         entry_in.serial      = SERIAL_MAX;
         entry_in.range_error = 1'b1;
      end else begin
         entry_in.serial      = t_sum[SERIAL_W-1:0];
         entry_in.range_error = 1'b0;
      end
   end

   // Sequence one item through divide, multiply, sum and push
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_chan.valid) begin
                  y_ff     <= y_in;
                  m_ff     <= m_in;
                  d_ff     <= req_chan.day_in;
                  off_ff   <= req_chan.day_offset;
                  state_ff <= F_DIV;
               end
            end
            F_DIV: begin
               qy_ff    <= qy_in;
               state_ff <= F_MUL;
            end
            F_MUL: begin
               p_ff     <= p_in;
               p365_ff  <= p365_in;
               pq_ff    <= pq_in;
               leap_ff  <= leap_in;
               state_ff <= F_SUM;
            end
            F_SUM: begin
               entry_ff <= entry_in;
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (push_ready) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign req_chan.ready = (state_ff == F_IDLE);
   assign push_valid     = (state_ff == F_PUSH);
   assign push_entry     = entry_ff;

endmodule

FILE: rtl/gdo_queue.sv
// Short register queue between front and back ends.
// Depends on gdo_pkg for the entry type.
module gdo_queue #(
   parameter int DEPTH = gdo_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  gdo_pkg::gdo_entry_type push_entry,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output gdo_pkg::gdo_entry_type pop_entry
);
   import gdo_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   gdo_entry_type    store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push_fire, pop_fire;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_entry  = store_ff[rd_ptr_ff];

   // Write entries
   always_ff @(posedge clock) begin
      if (push_fire) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop_fire) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_fire && !pop_fire) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_fire && !push_fire) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/gdo_back.sv
// Back end: splits a serial day into year, month and day by repeated subtraction.
// Depends on gdo_pkg and gdo_rsp_if.
module gdo_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  gdo_pkg::gdo_entry_type pop_entry,
   gdo_rsp_if.source              rsp_chan
);
   import gdo_pkg::*;

   typedef enum logic [2:0] {B_IDLE, B_Q400, B_Q100, B_Q4, B_Q1, B_MON, B_HOLD}
      back_state_type;

   back_state_type      state_ff;
   logic [SERIAL_W-1:0] n_ff;
   logic [SERIAL_W-1:0] t_ff;
   logic                err_ff;
   logic [YEAR_W-1:0]   year_ff;
   logic [MONTH_W-1:0]  mo_ff;
   logic [1:0]          q100_ff, q1_ff;
   logic [4:0]          q4_ff;
   logic                leap;
   logic [DAY_W-1:0]    mlen;

   // Leap year of the current year from the cycle counts
   assign leap = (q1_ff == Q_LAST) && ((q4_ff != Q4_LAST) || (q100_ff == Q_LAST));
   assign mlen = month_len(mo_ff, leap);

   // Walk 400-year, 100-year, 4-year, 1-year spans, then months
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         case (state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  n_ff     <= pop_entry.serial - 22'd1;
                  t_ff     <= pop_entry.serial;
                  err_ff   <= pop_entry.range_error;
                  year_ff  <= YEAR_MIN;
                  mo_ff    <= MON_JAN;
                  q100_ff  <= '0;
                  q4_ff    <= '0;
                  q1_ff    <= '0;
                  state_ff <= B_Q400;
               end
            end
            B_Q400: begin
               if (n_ff >= SERIAL_W'(DAYS_PER_400Y)) begin
                  n_ff    <= n_ff - SERIAL_W'(DAYS_PER_400Y);
                  year_ff <= year_ff + YEAR_W'(YEARS_400);
               end else begin
                  state_ff <= B_Q100;
               end
            end
            B_Q100: begin
               if ((q100_ff != Q_LAST) && (n_ff >= SERIAL_W'(DAYS_PER_100Y))) begin
                  n_ff    <= n_ff - SERIAL_W'(DAYS_PER_100Y);
                  year_ff <= year_ff + YEAR_W'(YEARS_CENTURY);
                  q100_ff <= q100_ff + 2'd1;
               end else begin
                  state_ff <= B_Q4;
               end
            end
            B_Q4: begin
               if (n_ff >= SERIAL_W'(DAYS_PER_4Y)) begin
                  n_ff    <= n_ff - SERIAL_W'(DAYS_PER_4Y);
                  year_ff <= year_ff + 14'd4;
                  q4_ff   <= q4_ff + 5'd1;
               end else begin
                  state_ff <= B_Q1;
               end
            end
            B_Q1: begin
               if ((q1_ff != Q_LAST) && (n_ff >= SERIAL_W'(DAYS_PER_YEAR))) begin
                  n_ff    <= n_ff - SERIAL_W'(DAYS_PER_YEAR);
                  year_ff <= year_ff + 14'd1;
                  q1_ff   <= q1_ff + 2'd1;
               end else begin
                  state_ff <= B_MON;
               end
            end
            B_MON: begin
               if ((mo_ff < MON_DEC) && (n_ff >= SERIAL_W'(mlen))) begin
                  n_ff  <= n_ff - SERIAL_W'(mlen);
                  mo_ff <= mo_ff + 4'd1;
               end else begin
                  state_ff <= B_HOLD;
               end
            end
            B_HOLD: begin
               if (rsp_chan.ready) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign pop_ready            = (state_ff == B_IDLE);
   assign rsp_chan.valid       = (state_ff == B_HOLD);
   assign rsp_chan.year_out    = year_ff;
   assign rsp_chan.month_out   = mo_ff;
   assign rsp_chan.day_out     = n_ff[DAY_W-1:0] + 5'd1;
   assign rsp_chan.day_number  = t_ff;
   assign rsp_chan.range_error = err_ff;

endmodule

FILE: rtl/gregorian_date_offset_and_day_number.sv
// Gregorian date offset and serial day number: adds a signed day count to a
// date and returns the normalised date, its serial day and a range flag.
//
// Request channel req_chan carries year_in, month_in, day_in and day_offset;
// response channel rsp_chan carries year_out, month_out, day_out, day_number
// and range_error. An item moves when valid and ready are both high.
// The front end steps each item through accept, divide by 100 through a
// reciprocal, multiply by 365, sum and clamp, and push into a short queue,
// taking no new item until it has pushed the last. The back end pops an
// entry and splits its serial day by compare-and-subtract steps, 400-, 100-,
// 4- and 1-year spans, then months, one step a cycle, and pops no new entry
// until its response is taken; that walk sets the rate. The front keeps
// accepting while a response waits; a stalled receiver holds the response
// stable, the queue then fills and req_chan.ready drops. Synchronous reset
// empties the queue and returns both ends to idle; there is no other state.
module gregorian_date_offset_and_day_number #(
   parameter int QUEUE_DEPTH = gdo_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   gdo_req_if.sink   req_chan,
   gdo_rsp_if.source rsp_chan
);
   import gdo_pkg::*;
   `include "gregorian_date_offset_and_day_number_macros.svh"

   logic          push_valid, push_ready, pop_valid, pop_ready;
   gdo_entry_type push_entry, pop_entry;
   logic          serial_at_end, date_in_calendar;

   gdo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   gdo_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   gdo_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_chan  (rsp_chan)
   );

   // Terms for the result checks
   assign serial_at_end    = (rsp_chan.day_number == SERIAL_MIN) ||
                             (rsp_chan.day_number == SERIAL_MAX);
   assign date_in_calendar = (rsp_chan.month_out >= MON_JAN) &&
                             (rsp_chan.month_out <= MON_DEC) && (rsp_chan.day_out != '0);

   // Front holds a pending entry until the queue takes it
   `GDO_ASSERT_NEXT(a_push_hold, clock, reset, push_valid && !push_ready, push_valid)
   // Back only pops when no response is outstanding
   `GDO_ASSERT_NOW(a_pop_idle, clock, reset, pop_valid && pop_ready, !rsp_chan.valid)
   // A flagged result sits at one end of the span
   `GDO_ASSERT_NOW(a_err_sat, clock, reset, rsp_chan.valid && rsp_chan.range_error, serial_at_end)
   // Result month and day stay in the calendar
   `GDO_ASSERT_NOW(a_date_ok, clock, reset, rsp_chan.valid, date_in_calendar)

endmodule
